// File: design/button_gesture_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// Button gesture detector assertion macros
// Concurrent assertion wrappers on aclk; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define BUTTON_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BGD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BGD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BGD_ASSERT(lbl, prop, msg)
`define BGD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: design/bgd_pkg.sv
// ----------------------------------------------------------------------------
// Button gesture detector package
// Shared constants, event codes, register map and interface structs.
// ----------------------------------------------------------------------------
package bgd_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int PIN_W       = 4;

    // event kinds, also the enable bit positions
    localparam logic [2:0] EV_PRESS   = 3'd0;
    localparam logic [2:0] EV_RELEASE = 3'd1;
    localparam logic [2:0] EV_CLICK   = 3'd2;
    localparam logic [2:0] EV_HOLD    = 3'd3;
    localparam logic [2:0] EV_TOCK    = 3'd4;
    localparam logic [2:0] EV_SWITCH  = 3'd5;

    // register indexes
    localparam logic [1:0] REG_ENABLES  = 2'd0;
    localparam logic [1:0] REG_GRACE    = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE = 2'd2;
    localparam logic [1:0] REG_PULSE    = 2'd3;

    localparam logic [5:0]  RST_ENABLES  = 6'd63;
    localparam logic [15:0] RST_GRACE    = 16'd400;
    localparam logic [9:0]  RST_DEBOUNCE = 10'd50;
    localparam logic [15:0] RST_PULSE    = 16'd1000;

    // datapath step phases
    localparam logic [1:0] PH_DEB = 2'd0;
    localparam logic [1:0] PH_HKA = 2'd1;
    localparam logic [1:0] PH_HKM = 2'd2;
    localparam logic [1:0] PH_HKB = 2'd3;

    localparam logic [1:0] LAST_SLOT = 2'd2;

    typedef struct packed {
        logic [5:0]  enables;
        logic [15:0] grace;
        logic [9:0]  debounce;
        logic [15:0] pulse;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  btn;
        logic [31:0] value;
    } evt_t;

    typedef struct packed {
        logic             start;
        logic [1:0]       phase;
        logic [BTN_W-1:0] btn;
        logic [1:0]       slot;
        logic             push;
        logic             commit;
        logic             flush;
        logic             finish;
    } cmd_t;

    typedef struct packed {
        logic fire;
        logic hk;
        logic evt_valid;
        logic can_push;
        logic pend_v;
    } sts_t;

endpackage

// File: design/button_gesture_detector_unit.sv
// Sequence: an item passes the idle and dispatch states; a debounce tick then steps
// through each button's event slots, housekeeping through the HKA, HKM and HKB phases
// of each button, and a flush sends out the held last event; back-pressure can stall them.
// The controller steps buttons one by one through a shared event unit.
// Throughput: one item at a time; the next is taken once the tick's events are queued.
// Reset: aresetn synchronous, active low; registers to defaults, time to 1.
// ----------------------------------------------------------------------------
// Button gesture detector top level
// Debounced press, release, click, hold, tock and switch events from button levels.
// ----------------------------------------------------------------------------
module button_gesture_detector_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] pin_levels
    input  logic        s_tuser,   // [0] housekeeping
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] event_kind, [5:3] button_number,
                                   // [37:6] event_value
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bgd_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    evt_t evt;

    bgd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bgd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bgd_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .in_pins (s_tdata[PIN_W-1:0]),
        .in_hk   (s_tuser),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_evt   (evt),
        .m_last  (m_tlast)
    );

    assign m_tdata = {2'b00, evt.value, evt.btn, evt.kind};

endmodule

// File: design/bgd_regs.sv
// ----------------------------------------------------------------------------
// Button gesture detector configuration registers
// APB-style register file holding enables and timing settings.
// ----------------------------------------------------------------------------
module bgd_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output bgd_pkg::cfg_t     cfg
);
    import bgd_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] idx;
    logic       wr;

    assign idx    = paddr[3:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // write registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enables  <= RST_ENABLES;
            cfg_reg.grace    <= RST_GRACE;
            cfg_reg.debounce <= RST_DEBOUNCE;
            cfg_reg.pulse    <= RST_PULSE;
        end else if (wr) begin
            unique case (idx)
                REG_ENABLES:  cfg_reg.enables  <= pwdata[5:0];
                REG_GRACE:    cfg_reg.grace    <= pwdata[15:0];
                REG_DEBOUNCE: cfg_reg.debounce <= pwdata[9:0];
                REG_PULSE:    cfg_reg.pulse    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (idx)
            REG_ENABLES:  prdata = {26'd0, cfg_reg.enables};
            REG_GRACE:    prdata = {16'd0, cfg_reg.grace};
            REG_DEBOUNCE: prdata = {22'd0, cfg_reg.debounce};
            REG_PULSE:    prdata = {16'd0, cfg_reg.pulse};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// File: design/bgd_ctrl.sv
// ----------------------------------------------------------------------------
// Button gesture detector controller
// Sequences debounce and housekeeping steps over the buttons.
// ----------------------------------------------------------------------------
module bgd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bgd_pkg::sts_t sts,
    output bgd_pkg::cmd_t cmd
);
    import bgd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_DEB   = 3'd2;
    localparam logic [2:0] ST_HKA   = 3'd3;
    localparam logic [2:0] ST_HKM   = 3'd4;
    localparam logic [2:0] ST_HKB   = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    localparam logic [BTN_W-1:0] BTN_LAST = BTN_W'(NUM_BUTTONS - 1);

    logic [2:0]       state_reg, state_next;
    logic [BTN_W-1:0] btn_reg, btn_next;
    logic [1:0]       slot_reg, slot_next;
    logic             adv;

    assign s_ready = (state_reg == ST_IDLE);
    // a slot moves on when it has no event or its event can be pushed
    assign adv     = !sts.evt_valid || sts.can_push;

    always_comb begin
        state_next = state_reg;
        btn_next   = btn_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        cmd.btn    = btn_reg;
        cmd.slot   = slot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                btn_next  = '0;
                slot_next = '0;
                if (sts.fire) begin
                    state_next = ST_DEB;
                end else if (sts.hk) begin
                    state_next = ST_HKA;
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_DEB: begin
                cmd.phase = PH_DEB;
                cmd.push  = sts.evt_valid && sts.can_push;
                if (adv) begin
                    if (slot_reg == LAST_SLOT) begin
                        cmd.commit = 1'b1;
                        slot_next  = '0;
                        if (btn_reg == BTN_LAST) begin
                            btn_next   = '0;
                            state_next = sts.hk ? ST_HKA : ST_FLUSH;
                        end else begin
                            btn_next = btn_reg + 1'b1;
                        end
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            ST_HKA: begin
                cmd.phase = PH_HKA;
                cmd.push  = sts.evt_valid && sts.can_push;
                if (adv) begin
                    cmd.commit = 1'b1;
                    state_next = ST_HKM;
                end
            end
            ST_HKM: begin
                cmd.phase  = PH_HKM;
                cmd.commit = 1'b1;
                state_next = ST_HKB;
            end
            ST_HKB: begin
                cmd.phase = PH_HKB;
                cmd.push  = sts.evt_valid && sts.can_push;
                if (adv) begin
                    cmd.commit = 1'b1;
                    if (btn_reg == BTN_LAST) begin
                        btn_next   = '0;
                        state_next = ST_FLUSH;
                    end else begin
                        btn_next   = btn_reg + 1'b1;
                        state_next = ST_HKA;
                    end
                end
            end
            ST_FLUSH: begin
                cmd.flush = 1'b1;
                if (!sts.pend_v) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            btn_reg   <= '0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            btn_reg   <= btn_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

// File: design/bgd_dp.sv
// ----------------------------------------------------------------------------
// Button gesture detector datapath
// Per-button state, event generation and the two-deep output stage.
// ----------------------------------------------------------------------------
`include "button_gesture_detector_unit_assert.svh"

module bgd_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bgd_pkg::cfg_t                 cfg,
    input  logic [bgd_pkg::PIN_W-1:0]     in_pins,
    input  logic                          in_hk,
    input  bgd_pkg::cmd_t                 cmd,
    output bgd_pkg::sts_t                 sts,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bgd_pkg::evt_t                 m_evt,
    output logic                          m_last
);
    import bgd_pkg::*;

    // tick state
    logic [31:0]            now_reg;
    logic [PIN_W-1:0]       raw_reg;
    logic [9:0]             qc_reg;
    logic [PIN_W-1:0]       pins_reg;
    logic                   fire_reg;
    logic                   hk_reg;

    // per-button state
    logic [NUM_BUTTONS-1:0] deb_reg;
    logic [NUM_BUTTONS-1:0] tog_reg;
    logic [NUM_BUTTONS-1:0] holding_reg;
    logic [31:0]            stamp_reg [NUM_BUTTONS];
    logic [7:0]             cc_reg    [NUM_BUTTONS];
    logic [7:0]             pc_reg    [NUM_BUTTONS];

    logic [31:0]            held_reg;
    logic [23:0]            due_reg;

    // output stage
    evt_t                   out_reg, pend_reg;
    logic                   out_v_reg, out_last_reg, pend_v_reg;

    logic [NUM_BUTTONS-1:0] lvl_vec;
    logic                   lvl, deb, tog, hold_b;
    logic [31:0]            stamp, dt, now_next;
    logic [7:0]             cc, pc;
    logic                   stamp_nz, ge, gt, cc_le1;
    logic                   c1, c1h, c1c, c2, clr_late, tock;
    logic [2:0]             ev_btn;
    logic                   ev_v [3];
    evt_t                   ev   [3];
    evt_t                   sel_ev;
    logic                   sel_v;
    logic                   out_free;

    assign lvl_vec  = NUM_BUTTONS'(pins_reg);
    assign lvl      = lvl_vec[cmd.btn];
    assign deb      = deb_reg[cmd.btn];
    assign tog      = tog_reg[cmd.btn];
    assign hold_b   = holding_reg[cmd.btn];
    assign stamp    = stamp_reg[cmd.btn];
    assign cc       = cc_reg[cmd.btn];
    assign pc       = pc_reg[cmd.btn];
    assign dt       = now_reg - stamp;
    assign stamp_nz = (stamp != 32'd0);
    assign ge       = (dt >= {16'd0, cfg.grace});
    assign gt       = (dt > {16'd0, cfg.grace});
    assign cc_le1   = (cc <= 8'd1);
    assign ev_btn   = 3'(32'(cmd.btn) + 32'd1);

    // housekeeping decisions
    assign c1       = stamp_nz && ge && !hold_b && deb;
    assign c1h      = c1 && cfg.enables[EV_HOLD] && cc_le1;
    assign c1c      = c1 && !c1h && cfg.enables[EV_CLICK] && (cc > 8'd1);
    assign c2       = stamp_nz && ge && !hold_b && !deb && (cc != 8'd0);
    assign clr_late = stamp_nz && gt && !deb;
    assign tock     = cfg.enables[EV_TOCK] && hold_b && cc_le1 && (pc != 8'hFF)
                      && (held_reg >= {8'd0, due_reg});

    // build the events of the current step
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ev_v[k]     = 1'b0;
            ev[k].kind  = EV_PRESS;
            ev[k].btn   = ev_btn;
            ev[k].value = 32'd0;
        end
        unique case (cmd.phase)
            PH_DEB: begin
                if (lvl != deb) begin
                    if (lvl) begin
                        ev_v[0]     = cfg.enables[EV_PRESS];
                        ev_v[1]     = cfg.enables[EV_SWITCH];
                        ev[1].kind  = EV_SWITCH;
                        ev[1].value = {31'd0, ~tog};
                        ev_v[2]     = cfg.enables[EV_CLICK] && (cc == 8'd0);
                        ev[2].kind  = EV_CLICK;
                    end else begin
                        ev_v[0]     = cfg.enables[EV_RELEASE];
                        ev[0].kind  = EV_RELEASE;
                        ev[0].value = dt;
                        ev_v[1]     = stamp_nz && ge && cc_le1 && cfg.enables[EV_HOLD];
                        ev[1].kind  = EV_HOLD;
                        ev[1].value = dt;
                        ev_v[2]     = ev_v[1];
                        ev[2].kind  = EV_TOCK;
                    end
                end
            end
            PH_HKA: begin
                if (c1h) begin
                    ev_v[0]    = 1'b1;
                    ev[0].kind = EV_HOLD;
                end else if (c1c) begin
                    ev_v[0]     = 1'b1;
                    ev[0].kind  = EV_CLICK;
                    ev[0].value = 32'd0 - {24'd0, cc};
                end else if (c2 && cfg.enables[EV_CLICK]) begin
                    ev_v[0]     = 1'b1;
                    ev[0].kind  = EV_CLICK;
                    ev[0].value = {24'd0, cc};
                end
            end
            PH_HKB: begin
                ev_v[0]     = tock;
                ev[0].kind  = EV_TOCK;
                ev[0].value = {24'd0, pc};
            end
            default: ;
        endcase
    end

    always_comb begin
        case (cmd.slot)
            2'd1:    begin sel_v = ev_v[1]; sel_ev = ev[1]; end
            2'd2:    begin sel_v = ev_v[2]; sel_ev = ev[2]; end
            default: begin sel_v = ev_v[0]; sel_ev = ev[0]; end
        endcase
    end

    assign out_free = !out_v_reg || m_ready;
    assign now_next = (now_reg == 32'hFFFF_FFFF) ? 32'd1 : now_reg + 32'd1;

    assign sts.fire      = fire_reg;
    assign sts.hk        = hk_reg;
    assign sts.evt_valid = sel_v;
    assign sts.can_push  = !pend_v_reg || out_free;
    assign sts.pend_v    = pend_v_reg;

    assign m_valid = out_v_reg;
    assign m_evt   = out_reg;
    assign m_last  = out_last_reg;

    // take the item, run the debounce countdown, advance time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg  <= 32'd1;
            raw_reg  <= '0;
            qc_reg   <= '0;
            pins_reg <= '0;
            fire_reg <= 1'b0;
            hk_reg   <= 1'b0;
        end else begin
            if (cmd.start) begin
                pins_reg <= in_pins;
                hk_reg   <= in_hk;
                fire_reg <= 1'b0;
                if (in_pins != raw_reg) begin
                    raw_reg <= in_pins;
                    qc_reg  <= (cfg.debounce == 10'd0) ? 10'd1 : cfg.debounce;
                end else if (qc_reg != 10'd0) begin
                    qc_reg   <= qc_reg - 10'd1;
                    fire_reg <= (qc_reg == 10'd1);
                end
            end
            if (cmd.finish) begin
                now_reg <= now_next;
            end
        end
    end

    // commit per-button state at the end of a step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg     <= '0;
            tog_reg     <= '0;
            holding_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                stamp_reg[i] <= '0;
                cc_reg[i]    <= '0;
                pc_reg[i]    <= '0;
            end
        end else if (cmd.commit) begin
            unique case (cmd.phase)
                PH_DEB: begin
                    if (lvl != deb) begin
                        deb_reg[cmd.btn] <= lvl;
                        if (lvl) begin
                            tog_reg[cmd.btn]   <= ~tog;
                            stamp_reg[cmd.btn] <= now_reg;
                            if (cc != 8'hFF) begin
                                cc_reg[cmd.btn] <= cc + 8'd1;
                            end
                        end
                    end
                end
                PH_HKA: begin
                    if (c1) begin
                        holding_reg[cmd.btn] <= 1'b1;
                    end
                    if (c1h && pc != 8'hFF) begin
                        pc_reg[cmd.btn] <= pc + 8'd1;
                    end
                    if (c2) begin
                        cc_reg[cmd.btn] <= 8'd0;
                    end
                    if (c1c || clr_late) begin
                        stamp_reg[cmd.btn]   <= '0;
                        pc_reg[cmd.btn]      <= '0;
                        cc_reg[cmd.btn]      <= '0;
                        holding_reg[cmd.btn] <= 1'b0;
                    end
                end
                PH_HKM: ;
                PH_HKB: begin
                    if (tock) begin
                        pc_reg[cmd.btn] <= pc + 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // elapsed time and tock due time for the tock check
    always_ff @(posedge aclk) begin
        if (cmd.commit && cmd.phase == PH_HKA) begin
            held_reg <= dt;
        end
        if (cmd.commit && cmd.phase == PH_HKM) begin
            due_reg <= cfg.pulse * pc;
        end
    end

    // hold the newest event back until the next one or the end of the tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg    <= 1'b0;
            pend_v_reg   <= 1'b0;
            out_last_reg <= 1'b0;
        end else begin
            if (out_v_reg && m_ready) begin
                out_v_reg <= 1'b0;
            end
            if (cmd.push) begin
                if (pend_v_reg) begin
                    out_reg      <= pend_reg;
                    out_last_reg <= 1'b0;
                    out_v_reg    <= 1'b1;
                end
                pend_reg   <= sel_ev;
                pend_v_reg <= 1'b1;
            end else if (cmd.flush && pend_v_reg && out_free) begin
                out_reg      <= pend_reg;
                out_last_reg <= 1'b1;
                out_v_reg    <= 1'b1;
                pend_v_reg   <= 1'b0;
            end
        end
    end

    `BGD_ASSERT(a_push_room, cmd.push |-> (!pend_v_reg || out_free), "push without room")
    `BGD_ASSERT(a_finish_empty, cmd.finish |-> !pend_v_reg, "tick ended with held item")
    `BGD_ASSERT(a_now_nonzero, now_reg != 32'd0, "time counter hit zero")
    `BGD_ASSERT_RST(a_rst_idle, !aresetn |=> (!out_v_reg && !pend_v_reg), "output not cleared")

endmodule

// File: sim/bgd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button gesture detector event checker
// Watches the tick, event and register channels, predicts the events of each
// accepted tick and compares them in order with the events the block sends.
// ----------------------------------------------------------------------------
module bgd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          outstanding
);
    import bgd_pkg::*;

    localparam int MAX_EVENTS = 20;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  btn;
        logic [31:0] value;
        logic        last;
    } gesture_t;

    gesture_t gesture_q[$];
    gesture_t tick_q[$];

    // register copy
    logic [5:0]  en_bits;
    logic [15:0] grace_ms;
    logic [9:0]  debounce_ms;
    logic [15:0] pulse_ms;

    // detector state copy
    logic [31:0] now_ms;
    logic [3:0]  raw_prev;
    logic [9:0]  quiet_cnt;
    logic        level   [NUM_BUTTONS];
    logic        toggle  [NUM_BUTTONS];
    logic [31:0] stamp   [NUM_BUTTONS];
    logic        holding [NUM_BUTTONS];
    logic [7:0]  clicks  [NUM_BUTTONS];
    logic [7:0]  pulses  [NUM_BUTTONS];

    function automatic logic kind_on(input logic [2:0] kind);
        return en_bits[kind];
    endfunction

    task automatic add_event(input logic [2:0] kind, input int b, input logic [31:0] value);
        gesture_t g;
        if (tick_q.size() < MAX_EVENTS) begin
            g.kind  = kind;
            g.btn   = 3'(b + 1);
            g.value = value;
            g.last  = 1'b0;
            tick_q.push_back(g);
        end
    endtask

    task automatic wipe_button(input int b);
        stamp[b]   = '0;
        pulses[b]  = '0;
        clicks[b]  = '0;
        holding[b] = 1'b0;
    endtask

    task automatic do_press(input int b);
        level[b] = 1'b1;
        if (kind_on(EV_PRESS)) add_event(EV_PRESS, b, 32'd0);
        toggle[b] = ~toggle[b];
        if (kind_on(EV_SWITCH)) add_event(EV_SWITCH, b, {31'd0, toggle[b]});
        stamp[b] = now_ms;
        if (clicks[b] == 8'd0 && kind_on(EV_CLICK)) add_event(EV_CLICK, b, 32'd0);
        if (clicks[b] != 8'd255) clicks[b] = clicks[b] + 8'd1;
    endtask

    task automatic do_release(input int b);
        logic [31:0] dt;
        dt = now_ms - stamp[b];
        level[b] = 1'b0;
        if (kind_on(EV_RELEASE)) add_event(EV_RELEASE, b, dt);
        if (stamp[b] != 0 && dt >= {16'd0, grace_ms} && clicks[b] <= 8'd1
                && kind_on(EV_HOLD)) begin
            add_event(EV_HOLD, b, dt);
            add_event(EV_TOCK, b, 32'd0);
        end
    endtask

    task automatic do_housekeep(input int b);
        logic [31:0] held;
        logic [63:0] due;
        held = now_ms - stamp[b];
        if (stamp[b] != 0) begin
            if (held >= {16'd0, grace_ms} && !holding[b] && level[b]) begin
                holding[b] = 1'b1;
                if (kind_on(EV_HOLD) && clicks[b] <= 8'd1) begin
                    add_event(EV_HOLD, b, 32'd0);
                    if (pulses[b] != 8'd255) pulses[b] = pulses[b] + 8'd1;
                end else if (kind_on(EV_CLICK) && clicks[b] > 8'd1) begin
                    add_event(EV_CLICK, b, 32'd0 - {24'd0, clicks[b]});
                    wipe_button(b);
                end
            end else if (held >= {16'd0, grace_ms} && !holding[b] && !level[b]
                         && clicks[b] != 0) begin
                if (kind_on(EV_CLICK)) add_event(EV_CLICK, b, {24'd0, clicks[b]});
                clicks[b] = '0;
            end
            if (held > {16'd0, grace_ms} && !level[b]) wipe_button(b);
        end
        if (kind_on(EV_TOCK) && holding[b] && clicks[b] <= 8'd1 && pulses[b] != 8'd255) begin
            due = {48'd0, pulse_ms} * {56'd0, pulses[b]};
            if ({32'd0, held} >= due) begin
                add_event(EV_TOCK, b, {24'd0, pulses[b]});
                pulses[b] = pulses[b] + 8'd1;
            end
        end
    endtask

    // work out the events of one millisecond tick
    task automatic predict_tick(input logic [3:0] pins, input logic hk);
        gesture_t g;
        tick_q.delete();
        if (pins != raw_prev) begin
            raw_prev  = pins;
            quiet_cnt = (debounce_ms != 0) ? debounce_ms : 10'd1;
        end else if (quiet_cnt != 0) begin
            quiet_cnt = quiet_cnt - 10'd1;
            if (quiet_cnt == 0) begin
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    if (pins[b] != level[b]) begin
                        if (pins[b]) do_press(b);
                        else do_release(b);
                    end
                end
            end
        end
        if (hk) begin
            for (int b = 0; b < NUM_BUTTONS; b++) do_housekeep(b);
        end
        if (tick_q.size() > 0) begin
            g = tick_q.pop_back();
            g.last = 1'b1;
            tick_q.push_back(g);
        end
        foreach (tick_q[i]) gesture_q.push_back(tick_q[i]);
        now_ms = now_ms + 32'd1;
        if (now_ms == 0) now_ms = 32'd1;
    endtask

    task automatic check_event();
        gesture_t want;
        logic [2:0]  got_kind;
        logic [2:0]  got_btn;
        logic [31:0] got_value;
        got_kind  = m_tdata[2:0];
        got_btn   = m_tdata[5:3];
        got_value = m_tdata[37:6];
        if (gesture_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("checker: unexpected event kind %0d button %0d value %0d last %0b",
                         got_kind, got_btn, $signed(got_value), m_tlast);
        end else begin
            want = gesture_q.pop_front();
            if (got_kind !== want.kind || got_btn !== want.btn
                    || got_value !== want.value || m_tlast !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("checker: mismatch expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                             want.kind, want.btn, $signed(want.value), want.last,
                             got_kind, got_btn, $signed(got_value), m_tlast);
            end
        end
    endtask

    // sample on the falling edge, ahead of the rising edge at which items move
    always @(negedge aclk) begin
        if (!aresetn) begin
            errors      = 0;
            en_bits     = RST_ENABLES;
            grace_ms    = RST_GRACE;
            debounce_ms = RST_DEBOUNCE;
            pulse_ms    = RST_PULSE;
            now_ms      = 32'd1;
            raw_prev    = '0;
            quiet_cnt   = '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                level[b]  = 1'b0;
                toggle[b] = 1'b0;
                wipe_button(b);
            end
            gesture_q.delete();
            outstanding = 0;
        end else begin
            if (m_tvalid && m_tready) check_event();
            if (s_tvalid && s_tready) predict_tick(s_tdata[3:0], s_tuser);
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ENABLES:  en_bits     = pwdata[5:0];
                    REG_GRACE:    grace_ms    = pwdata[15:0];
                    REG_DEBOUNCE: debounce_ms = pwdata[9:0];
                    REG_PULSE:    pulse_ms    = pwdata[15:0];
                    default: ;
                endcase
            end
            outstanding = gesture_q.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button gesture detector testbench
// Drives millisecond ticks with button levels, rewrites the registers between
// phases and lets the checker compare every event; gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import bgd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [3:0] pin_levels
    logic        s_tuser;   // [0] housekeeping
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [2:0] event_kind, [5:3] button_number, [37:6] event_value
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int outstanding;
    int tx_idle_pct;
    int rx_idle_pct;
    logic stall_req;
    logic stall_done;
    int stall_cnt;
    int quiet_cycles = 0;
    logic [3:0] pins_now;

    button_gesture_detector_unit DUT (.*);

    bgd_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_done <= 1'b0;
            stall_cnt  <= 0;
        end else if (stall_req && !stall_done) begin
            stall_done <= 1'b1;
            stall_cnt  <= 400;
            m_tready   <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic send_tick(input logic [3:0] pins, input logic hk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, pins};
        s_tuser  <= hk;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // setup then access; the caller drops the select after the last write
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        @(posedge aclk);
    endtask

    // let every expected event drain and the block fall idle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [5:0] en, input logic [15:0] grace,
                            input logic [9:0] deb, input logic [15:0] pulse);
        drain();
        reg_write(REG_ENABLES, {26'd0, en});
        reg_write(REG_GRACE, {16'd0, grace});
        reg_write(REG_DEBOUNCE, {22'd0, deb});
        reg_write(REG_PULSE, {16'd0, pulse});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // gestures: levels held for a few ticks, with short glitches mixed in
    task automatic run_gestures(input int count);
        int dur;
        logic [3:0] glitch;
        while (count > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                glitch = 4'($urandom_range(0, 15));
                send_tick(glitch, 1'($urandom_range(0, 1)));
                count--;
            end else if ($urandom_range(0, 2) == 0) begin
                pins_now = 4'($urandom_range(0, 15));
            end else begin
                pins_now = pins_now ^ (4'd1 << $urandom_range(0, 3));
            end
            dur = $urandom_range(1, 8);
            repeat (dur) begin
                if (count > 0) begin
                    send_tick(pins_now, ($urandom_range(0, 99) < 60));
                    count--;
                end
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle_pct = 17;
        rx_idle_pct = 46;
        stall_req   = 1'b0;
        pins_now    = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: press and hold with tocks, multi-click, click-hold, all pins
        set_regs(6'd63, 16'd3, 10'd1, 16'd2);
        send_tick(4'd1, 1'b0);
        send_tick(4'd1, 1'b0);
        repeat (4) send_tick(4'd1, 1'b1);
        send_tick(4'd0, 1'b0);
        send_tick(4'd0, 1'b1);
        send_tick(4'd2, 1'b0);
        send_tick(4'd2, 1'b0);
        send_tick(4'd0, 1'b0);
        send_tick(4'd0, 1'b0);
        send_tick(4'd2, 1'b0);
        send_tick(4'd2, 1'b0);
        repeat (4) send_tick(4'd0, 1'b1);
        send_tick(4'd4, 1'b0);
        send_tick(4'd4, 1'b0);
        send_tick(4'd0, 1'b0);
        send_tick(4'd0, 1'b0);
        send_tick(4'd4, 1'b0);
        repeat (4) send_tick(4'd4, 1'b1);
        // all pins pressed after the click-hold wiped the stamp; released in the masked phase below
        send_tick(4'd15, 1'b0);
        send_tick(4'd15, 1'b1);

        // all events masked, then the largest register values
        set_regs(6'd0, 16'd1, 10'd1, 16'd1);
        send_tick(4'd0, 1'b1);
        send_tick(4'd0, 1'b1);
        set_regs(6'd63, 16'hFFFF, 10'd1023, 16'hFFFF);
        send_tick(4'd8, 1'b1);
        send_tick(4'd8, 1'b1);

        // random phases under changing idling and register settings
        set_regs(6'd63, 16'($urandom_range(2, 12)), 10'($urandom_range(1, 4)),
                 16'($urandom_range(1, 6)));
        tx_idle_pct = 17;
        rx_idle_pct = 46;
        run_gestures(40);

        set_regs(6'($urandom_range(0, 63)) | 6'd24, 16'($urandom_range(2, 8)), 10'd1,
                 16'($urandom_range(1, 3)));
        tx_idle_pct = 46;
        rx_idle_pct = 17;
        run_gestures(15);
        stall_req   = 1'b1;
        run_gestures(25);

        set_regs(6'd63, 16'd1, 10'd1, 16'd1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_gestures(40);

        drain();
        if (errors == 0 && outstanding == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
